// ----- hdl/round_robin_thread_scheduler_core_defines.svh -----
// assertion macros shared by the scheduler rtl
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// next-cycle implication
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

// ----- hdl/rrts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// types and codes of the round-robin thread scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int OUT_ID_W = 16;

   // register byte addresses on the apb port
   localparam logic [1:0] CSR_ENABLE = 2'd0;

   typedef enum logic [2:0] {
      OP_CREATE  = 3'd0,
      OP_JOIN    = 3'd1,
      OP_PREEMPT = 3'd2,
      OP_FINISH  = 3'd3,
      OP_DESTROY = 3'd4,
      OP_SELF    = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_RUN_WAIT,
      ST_JNR_WAIT,
      ST_DISP,
      ST_DISP_RING,
      ST_DISP_REC,
      ST_RESP
   } state_type;

   localparam logic [1:0] SS_READY    = 2'd0;
   localparam logic [1:0] SS_RUNNING  = 2'd1;
   localparam logic [1:0] SS_BLOCKED  = 2'd2;
   localparam logic [1:0] SS_FINISHED = 2'd3;

endpackage

// ----- hdl/round_robin_thread_scheduler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// thread table and fifo ready queue with create, join, yield, self, finish, destroy
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; busy then stays high
// until the response has been shown. the response is on the rsp_ ports for
// exactly one cycle, marked by rsp_valid; the receiver cannot stall it.
// one request is handled at a time. a dispatch reads the ready queue head and
// then the slot record; preempt/finish do a read-modify-write of the running
// slot. create, join and destroy scan the slot memory: create checks one slot
// a cycle, join and destroy pass a read state and a check state for each slot
// (memory read latency).
// slot records (id, status, joiner) sit in one memory, the ready queue in a
// second; slot entries never written read as their reset value via valid bits.
// reset restores the main thread (id 0) as running and clears enable; the apb
// port (enable at address 0) should only be written while busy is low.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_core #(
   parameter int MAX_SLOTS = 16,
   parameter int ID_BITS   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [2:0]                     req_operation,
   input  logic [rrts_pkg::OUT_ID_W-1:0]  req_target_id,
   output logic                           rsp_valid,
   output logic                           rsp_status,
   output logic [rrts_pkg::OUT_ID_W-1:0]  rsp_result_id,
   output logic                           rsp_running_valid,
   output logic [rrts_pkg::OUT_ID_W-1:0]  rsp_running_id,
   output logic                           rsp_switched,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [1:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import rrts_pkg::*;
   `include "round_robin_thread_scheduler_core_defines.svh"

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = SLOT_W + 1;
   localparam int REC_W  = ID_BITS + 3 + SLOT_W;
   localparam int CMP_W  = (ID_BITS > OUT_ID_W) ? ID_BITS : OUT_ID_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);

   state_type             state_ff, state_in;
   logic                  enable_ff;
   logic [2:0]            op_ff, op_in;
   logic [OUT_ID_W-1:0]   tid_ff, tid_in;
   logic [SLOT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [MAX_SLOTS-1:0]  used_ff, used_in;
   logic [MAX_SLOTS-1:0]  valid_ff, valid_in;
   logic [SLOT_W-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SLOT_W-1:0]     running_slot_ff, running_slot_in;
   logic                  running_flag_ff, running_flag_in;
   logic [ID_BITS-1:0]    running_id_ff, running_id_in;
   logic [ID_BITS:0]      next_id_ff, next_id_in;
   logic [SLOT_W-1:0]     rd_addr_ff;
   logic                  status_ff, status_in;
   logic [OUT_ID_W-1:0]   result_ff, result_in;
   logic                  sw_ff, sw_in;

   logic                  slot_we;
   logic [SLOT_W-1:0]     slot_waddr, slot_raddr;
   logic [REC_W-1:0]      slot_wdata, slot_q;
   logic                  ring_we;
   logic [SLOT_W-1:0]     ring_waddr, ring_raddr, ring_wdata, ring_q;
   logic                  push_req;
   logic [SLOT_W-1:0]     push_slot;

   logic [ID_BITS-1:0]    rec_id;
   logic [1:0]            rec_st;
   logic                  rec_jv;
   logic [SLOT_W-1:0]     rec_jn;
   logic                  id_match, scan_last, ids_left, can_push, join_ok;
   logic [CMP_W-1:0]      run_id_ext;

   rrts_ram #(.WIDTH(REC_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
      .clock(clock), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
      .raddr(slot_raddr), .rdata(slot_q)
   );

   rrts_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_ring_ram (
      .clock(clock), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
      .raddr(ring_raddr), .rdata(ring_q)
   );

   // a slot never written reads as its reset record
   always_comb begin
      if (valid_ff[rd_addr_ff]) begin
         rec_id = slot_q[REC_W-1 -: ID_BITS];
         rec_st = slot_q[SLOT_W+2:SLOT_W+1];
         rec_jv = slot_q[SLOT_W];
         rec_jn = slot_q[SLOT_W-1:0];
      end else begin
         rec_id = '0;
         rec_st = (rd_addr_ff == '0) ? SS_RUNNING : SS_READY;
         rec_jv = 1'b0;
         rec_jn = '0;
      end
   end

   assign run_id_ext = CMP_W'(running_id_ff);
   assign id_match   = used_ff[rd_addr_ff] && (CMP_W'(rec_id) == CMP_W'(tid_ff));
   assign scan_last  = (scan_idx_ff == LAST_SLOT);
   assign ids_left   = !next_id_ff[ID_BITS];
   assign can_push   = (count_ff < CNT_W'(MAX_SLOTS));
   assign join_ok    = running_flag_ff && (CMP_W'(req_target_id) != run_id_ext);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!enable_ff) begin
                  state_in = ST_RESP;
               end else begin
                  case (req_operation) inside
                     OP_CREATE:  state_in = ST_SCAN;
                     OP_JOIN:    state_in = join_ok ? ST_SCAN : ST_DISP;
                     OP_DESTROY: state_in = (req_target_id != '0) ? ST_SCAN : ST_DISP;
                     OP_PREEMPT, OP_FINISH:
                                 state_in = running_flag_ff ? ST_RUN_WAIT : ST_DISP;
                     default:    state_in = ST_DISP;
                  endcase
               end
            end
         end
         ST_SCAN: begin
            if (op_ff == OP_CREATE) begin
               if (!used_ff[scan_idx_ff] || scan_last) begin
                  state_in = ST_DISP;
               end
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (id_match) begin
               state_in = (op_ff == OP_JOIN && rec_st != SS_FINISHED) ? ST_RUN_WAIT
                                                                     : ST_DISP;
            end else begin
               state_in = scan_last ? ST_DISP : ST_SCAN;
            end
         end
         ST_RUN_WAIT: begin
            state_in = (op_ff == OP_FINISH && rec_jv && used_ff[rec_jn]) ? ST_JNR_WAIT
                                                                        : ST_DISP;
         end
         ST_JNR_WAIT:  state_in = ST_DISP;
         ST_DISP: begin
            state_in = (!running_flag_ff && count_ff != '0) ? ST_DISP_RING : ST_RESP;
         end
         ST_DISP_RING: state_in = ST_DISP_REC;
         ST_DISP_REC:  state_in = ST_RESP;
         ST_RESP:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in           = op_ff;
      tid_in          = tid_ff;
      scan_idx_in     = scan_idx_ff;
      used_in         = used_ff;
      valid_in        = valid_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      running_slot_in = running_slot_ff;
      running_flag_in = running_flag_ff;
      running_id_in   = running_id_ff;
      next_id_in      = next_id_ff;
      status_in       = status_ff;
      result_in       = result_ff;
      sw_in           = sw_ff;
      slot_we         = 1'b0;
      slot_waddr      = running_slot_ff;
      slot_wdata      = '0;
      slot_raddr      = running_slot_ff;
      ring_raddr      = head_ff;
      push_req        = 1'b0;
      push_slot       = running_slot_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in       = req_operation;
               tid_in      = req_target_id;
               scan_idx_in = '0;
               status_in   = 1'b1;
               result_in   = '0;
               sw_in       = 1'b0;
               if (enable_ff && req_operation == OP_SELF && running_flag_ff) begin
                  status_in = 1'b0;
                  result_in = run_id_ext[OUT_ID_W-1:0];
               end
            end
         end
         ST_SCAN: begin
            slot_raddr = scan_idx_ff;
            if (op_ff == OP_CREATE) begin
               if (!used_ff[scan_idx_ff]) begin
                  if (ids_left) begin
                     slot_we    = 1'b1;
                     slot_waddr = scan_idx_ff;
                     slot_wdata = {next_id_ff[ID_BITS-1:0], SS_READY, 1'b0, SLOT_W'(0)};
                     used_in[scan_idx_ff] = 1'b1;
                     push_req   = 1'b1;
                     push_slot  = scan_idx_ff;
                     result_in  = OUT_ID_W'(next_id_ff);
                     next_id_in = next_id_ff + 1'b1;
                     status_in  = 1'b0;
                  end
               end else if (!scan_last) begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
         end
         ST_SCAN_CHK: begin
            if (id_match) begin
               if (op_ff == OP_JOIN) begin
                  status_in = 1'b0;
                  if (rec_st != SS_FINISHED) begin
                     slot_we    = 1'b1;
                     slot_waddr = rd_addr_ff;
                     slot_wdata = {rec_id, rec_st, 1'b1, running_slot_ff};
                  end
               end else if (rd_addr_ff != '0 && rec_st == SS_FINISHED) begin
                  used_in[rd_addr_ff] = 1'b0;
                  status_in = 1'b0;
               end
            end else if (!scan_last) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_RUN_WAIT: begin
            slot_we         = 1'b1;
            running_flag_in = 1'b0;
            status_in       = 1'b0;
            case (op_ff)
               OP_JOIN:    slot_wdata = {rec_id, SS_BLOCKED, rec_jv, rec_jn};
               OP_PREEMPT: begin
                  slot_wdata = {rec_id, SS_READY, rec_jv, rec_jn};
                  push_req   = 1'b1;
               end
               default: begin
                  slot_wdata = {rec_id, SS_FINISHED, 1'b0, rec_jn};
                  slot_raddr = rec_jn;
               end
            endcase
         end
         ST_JNR_WAIT: begin
            if (rec_st == SS_BLOCKED) begin
               slot_we    = 1'b1;
               slot_waddr = rd_addr_ff;
               slot_wdata = {rec_id, SS_READY, rec_jv, rec_jn};
               push_req   = 1'b1;
               push_slot  = rd_addr_ff;
            end
         end
         ST_DISP: begin
            ring_raddr = head_ff;
         end
         ST_DISP_RING: begin
            slot_raddr = ring_q;
            head_in    = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
            count_in   = count_ff - 1'b1;
         end
         ST_DISP_REC: begin
            slot_we         = 1'b1;
            slot_waddr      = rd_addr_ff;
            slot_wdata      = {rec_id, SS_RUNNING, rec_jv, rec_jn};
            running_slot_in = rd_addr_ff;
            running_id_in   = rec_id;
            running_flag_in = 1'b1;
            sw_in           = 1'b1;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase

      if (slot_we) begin
         valid_in[slot_waddr] = 1'b1;
      end
      ring_we    = push_req && can_push;
      ring_waddr = tail_ff;
      ring_wdata = push_slot;
      if (ring_we) begin
         tail_in  = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         enable_ff       <= 1'b0;
         used_ff         <= MAX_SLOTS'(1);
         valid_ff        <= '0;
         head_ff         <= '0;
         tail_ff         <= '0;
         count_ff        <= '0;
         running_slot_ff <= '0;
         running_flag_ff <= 1'b1;
         running_id_ff   <= '0;
         next_id_ff      <= (ID_BITS + 1)'(1);
      end else begin
         state_ff        <= state_in;
         used_ff         <= used_in;
         valid_ff        <= valid_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         count_ff        <= count_in;
         running_slot_ff <= running_slot_in;
         running_flag_ff <= running_flag_in;
         running_id_ff   <= running_id_in;
         next_id_ff      <= next_id_in;
         if (psel && penable && pwrite && paddr == CSR_ENABLE) begin
            enable_ff <= pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tid_ff      <= tid_in;
      scan_idx_ff <= scan_idx_in;
      rd_addr_ff  <= slot_raddr;
      status_ff   <= status_in;
      result_ff   <= result_in;
      sw_ff       <= sw_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_status        = status_ff;
   assign rsp_result_id     = result_ff;
   assign rsp_running_valid = running_flag_ff;
   assign rsp_running_id    = running_flag_ff ? run_id_ext[OUT_ID_W-1:0] : '0;
   assign rsp_switched      = sw_ff;
   assign prdata            = (paddr == CSR_ENABLE) ? {31'b0, enable_ff} : '0;
   assign pready            = 1'b1;

   `RRTS_ASSERT_NEXT(a_resp_then_idle, clock, reset, rsp_valid, !busy)
   `RRTS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `RRTS_ASSERT_NOW(a_switch_runs, clock, reset, rsp_valid && rsp_switched, rsp_running_valid)
   `RRTS_ASSERT_NOW(a_ring_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_SLOTS))
endmodule

// ----- hdl/rrts_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the round-robin thread scheduler core
// ----------------------------------------------------------------------------
// a queue of pending requests feeds a clocked driver with random gaps; every
// accepted transaction is run through a local scheduler model and the
// predicted response is queued; a clocked monitor compares each rsp_valid
// transaction with the oldest prediction. enable is written between phases
// over the apb port while the core is idle.
// ----------------------------------------------------------------------------
module testbench;
   import rrts_pkg::*;

   localparam int SLOTS = 16;
   localparam logic [2:0] OP_UNUSED6 = 3'd6;
   localparam logic [2:0] OP_UNUSED7 = 3'd7;
   localparam logic [1:0] ADDR_ENABLE = 2'd0;
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic [2:0]  op;
      logic [15:0] tid;
   } sched_req_type;

   typedef struct {
      logic        status;
      logic [15:0] result_id;
      logic        running_valid;
      logic [15:0] running_id;
      logic        switched;
   } sched_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [2:0]  req_operation = OP_CREATE;
   logic [15:0] req_target_id = '0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = ADDR_ENABLE;
   logic [31:0] pwdata = '0;
   logic        busy, rsp_valid, rsp_status, rsp_running_valid, rsp_switched, pready;
   logic [15:0] rsp_result_id, rsp_running_id;
   logic [31:0] prdata;

   round_robin_thread_scheduler_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_target_id(req_target_id),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_result_id(rsp_result_id),
      .rsp_running_valid(rsp_running_valid), .rsp_running_id(rsp_running_id),
      .rsp_switched(rsp_switched), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scheduler model state
   bit          m_enable;
   bit          m_used [SLOTS];
   logic [16:0] m_id [SLOTS];
   logic [1:0]  m_stat [SLOTS];
   bit          m_jvalid [SLOTS];
   logic [3:0]  m_joiner [SLOTS];
   logic [3:0]  m_ring [SLOTS];
   int          m_head, m_tail, m_count;
   logic [3:0]  m_run_slot;
   bit          m_run_flag;
   logic [16:0] m_next_id;

   sched_req_type pending_reqs [$];
   sched_rsp_type expected_rsps [$];
   int          mismatches = 0;
   int          gap_left = 0;
   bit          calm = 0;
   int          quiet_cycles = 0;
   bit          apb_active = 0;
   int          ids_issued = 0;

   task automatic model_reset();
      for (int i = 0; i < SLOTS; i++) begin
         m_used[i] = (i == 0);
         m_id[i] = '0;
         m_stat[i] = (i == 0) ? SS_RUNNING : SS_READY;
         m_jvalid[i] = 0;
         m_joiner[i] = '0;
         m_ring[i] = '0;
      end
      m_enable = 0;
      m_head = 0; m_tail = 0; m_count = 0;
      m_run_slot = '0; m_run_flag = 1; m_next_id = 17'd1;
   endtask

   task automatic ring_push(input logic [3:0] s);
      if (m_count < SLOTS) begin
         m_ring[m_tail] = s;
         m_tail = (m_tail + 1) % SLOTS;
         m_count++;
      end
   endtask

   function automatic int lookup_slot(input logic [15:0] tid);
      for (int i = 0; i < SLOTS; i++)
         if (m_used[i] && m_id[i] == {1'b0, tid}) return i;
      return -1;
   endfunction

   task automatic schedule_event(input logic [2:0] op, input logic [15:0] tid,
                                 output sched_rsp_type r);
      int t;
      r.status = STATUS_FAIL;
      r.result_id = '0;
      r.switched = 0;
      if (m_enable) begin
         case (op)
            OP_CREATE: begin
               t = -1;
               for (int i = SLOTS - 1; i >= 0; i--) if (!m_used[i]) t = i;
               if (t >= 0 && m_next_id < 17'h10000) begin
                  m_used[t] = 1;
                  m_id[t] = m_next_id;
                  m_stat[t] = SS_READY;
                  m_jvalid[t] = 0;
                  m_joiner[t] = '0;
                  r.result_id = m_next_id[15:0];
                  m_next_id++;
                  ring_push(t[3:0]);
                  r.status = STATUS_OK;
               end
            end
            OP_JOIN: begin
               t = lookup_slot(tid);
               if (m_run_flag && {1'b0, tid} != m_id[m_run_slot] && t >= 0) begin
                  r.status = STATUS_OK;
                  if (m_stat[t] != SS_FINISHED) begin
                     m_stat[m_run_slot] = SS_BLOCKED;
                     m_jvalid[t] = 1;
                     m_joiner[t] = m_run_slot;
                     m_run_flag = 0;
                  end
               end
            end
            OP_PREEMPT: if (m_run_flag) begin
               m_stat[m_run_slot] = SS_READY;
               ring_push(m_run_slot);
               m_run_flag = 0;
               r.status = STATUS_OK;
            end
            OP_FINISH: if (m_run_flag) begin
               m_stat[m_run_slot] = SS_FINISHED;
               if (m_jvalid[m_run_slot]) begin
                  m_jvalid[m_run_slot] = 0;
                  t = m_joiner[m_run_slot];
                  if (m_used[t] && m_stat[t] == SS_BLOCKED) begin
                     m_stat[t] = SS_READY;
                     ring_push(t[3:0]);
                  end
               end
               m_run_flag = 0;
               r.status = STATUS_OK;
            end
            OP_DESTROY: begin
               t = lookup_slot(tid);
               if (tid != 0 && t > 0 && m_stat[t] == SS_FINISHED) begin
                  m_used[t] = 0;
                  m_jvalid[t] = 0;
                  m_joiner[t] = '0;
                  r.status = STATUS_OK;
               end
            end
            OP_SELF: if (m_run_flag) begin
               r.result_id = m_id[m_run_slot][15:0];
               r.status = STATUS_OK;
            end
            default: ;
         endcase
         // dispatch the queue head whenever nothing runs
         if (!m_run_flag && m_count > 0) begin
            t = m_ring[m_head];
            m_head = (m_head + 1) % SLOTS;
            m_count--;
            m_stat[t] = SS_RUNNING;
            m_run_slot = t[3:0];
            m_run_flag = 1;
            r.switched = 1;
         end
      end
      r.running_valid = m_run_flag;
      r.running_id = m_run_flag ? m_id[m_run_slot][15:0] : 16'd0;
   endtask

   // driver
   always @(posedge clock) begin
      sched_req_type nxt;
      sched_rsp_type exp_rsp;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            schedule_event(req_operation, req_target_id, exp_rsp);
            expected_rsps.push_back(exp_rsp);
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               req_operation <= nxt.op;
               req_target_id <= nxt.tid;
               start <= 1'b1;
               if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 14);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      sched_rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transaction");
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status || rsp_result_id !== e.result_id ||
                rsp_running_valid !== e.running_valid || rsp_running_id !== e.running_id ||
                rsp_switched !== e.switched) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected st=%0d res=%0d rv=%0d rid=%0d sw=%0d,",
                            " got st=%0d res=%0d rv=%0d rid=%0d sw=%0d"},
                           e.status, e.result_id, e.running_valid, e.running_id, e.switched,
                           rsp_status, rsp_result_id, rsp_running_valid, rsp_running_id,
                           rsp_switched);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || apb_active) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_enable(input bit value);
      apb_active = 1;
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= ADDR_ENABLE; pwdata <= {31'($urandom()), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      m_enable = value;
      apb_active = 0;
   endtask

   task automatic add_req(input logic [2:0] op, input logic [15:0] tid);
      sched_req_type q;
      q.op = op;
      q.tid = tid;
      pending_reqs.push_back(q);
      if (op == OP_CREATE) ids_issued++;
   endtask

   // sender pauses here until every prediction has been compared
   task automatic drain();
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !start);
      repeat (2 * SLOTS + 10) @(posedge clock);
   endtask

   task automatic add_random(input int n);
      int w, lo;
      logic [2:0] op;
      logic [15:0] tid;
      for (int k = 0; k < n; k++) begin
         w = $urandom_range(0, 99);
         if (w < 25) op = OP_CREATE;
         else if (w < 40) op = OP_JOIN;
         else if (w < 55) op = OP_PREEMPT;
         else if (w < 68) op = OP_FINISH;
         else if (w < 88) op = OP_DESTROY;
         else if (w < 96) op = OP_SELF;
         else op = $urandom_range(0, 1) ? OP_UNUSED6 : OP_UNUSED7;
         // mostly ids that were recently handed out
         lo = (ids_issued > 20) ? ids_issued - 20 : 0;
         if ($urandom_range(0, 9) < 8) tid = 16'($urandom_range(lo, ids_issued + 1));
         else tid = 16'($urandom());
         add_req(op, tid);
      end
   endtask

   initial begin
      model_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled: everything refused
      write_enable(1'b0);
      add_req(OP_CREATE, 16'd0);
      add_req(OP_SELF, 16'd0);
      add_req(OP_PREEMPT, 16'd0);
      drain();

      write_enable(1'b1);
      add_req(OP_SELF, 16'd0);
      add_req(OP_JOIN, 16'd0);        // join of self
      add_req(OP_JOIN, 16'hFFFF);     // unknown id
      add_req(OP_DESTROY, 16'd0);     // main cannot go
      add_req(OP_DESTROY, 16'd999);
      add_req(OP_UNUSED6, 16'd1);
      add_req(OP_UNUSED7, 16'd1);
      for (int i = 0; i < 16; i++) add_req(OP_CREATE, 16'd0); // last one finds table full
      add_req(OP_JOIN, 16'd1);        // main blocks on thread 1
      add_req(OP_FINISH, 16'd0);      // 1 finishes, wakes main
      add_req(OP_JOIN, 16'd1);        // finished target
      add_req(OP_DESTROY, 16'd1);
      add_req(OP_DESTROY, 16'd3);     // not finished
      add_req(OP_PREEMPT, 16'd0);
      drain();

      // run everything down to idle, then requests with no thread running
      for (int i = 0; i < 17; i++) add_req(OP_FINISH, 16'd0);
      add_req(OP_PREEMPT, 16'd0);
      add_req(OP_JOIN, 16'd5);
      add_req(OP_SELF, 16'd0);
      add_req(OP_CREATE, 16'd0);
      drain();

      add_random(350);
      drain();
      write_enable(1'b0);
      add_random(40);
      drain();
      write_enable(1'b1);
      add_random(350);
      drain();
      write_enable(1'b1);
      add_random(200);
      wait (pending_reqs.size() < 100);
      calm = 1;
      add_random(100);

      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !start);
      repeat (2 * SLOTS + 10) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
